// ----- hdl/srr_pkg.sv -----
// Shared constants, types and state encoding for the selective-repeat receiver.
`timescale 1ns / 1ps

package srr_pkg;

    localparam int SEQ_MOD     = 8;
    localparam int SEQ_W       = (SEQ_MOD > 1) ? $clog2(SEQ_MOD) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int ACK_W       = 9;
    localparam int SEQ_IN_W    = 8;
    localparam int PAY_W       = 64;
    localparam int WIN_W       = 3;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // Register index, taken from paddr[ADDR_W-1]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);
    localparam logic [ACK_W-1:0] ACK_NONE     = {ACK_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACK,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic eval;
        logic load_ack;
        logic load_dlv;
    } t_cmd;

    typedef struct packed {
        logic in_order;
        logic out_free;
        logic run_last;
    } t_status;

endpackage

// ----- hdl/srr_ctrl.sv -----
// Controller state machine: sequences capture, evaluation and the result run.
`timescale 1ns / 1ps

module srr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  srr_pkg::t_status i_sts,
    output srr_pkg::t_cmd    o_cmd
);

    srr_pkg::t_state r_state;
    srr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            srr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = srr_pkg::ST_EVAL;
                end
            end
            srr_pkg::ST_EVAL: begin
                n_state = i_sts.in_order ? srr_pkg::ST_DRAIN : srr_pkg::ST_ACK;
            end
            srr_pkg::ST_ACK: begin
                if (i_sts.out_free) begin
                    n_state = srr_pkg::ST_IDLE;
                end
            end
            srr_pkg::ST_DRAIN: begin
                if (i_sts.out_free && i_sts.run_last) begin
                    n_state = srr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            srr_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_valid;
            end
            srr_pkg::ST_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            srr_pkg::ST_ACK: begin
                o_cmd.load_ack = i_sts.out_free;
            end
            srr_pkg::ST_DRAIN: begin
                o_cmd.load_dlv = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/srr_dpath.sv -----
// Datapath: packet capture, slot buffer, sequence state and output register.
`timescale 1ns / 1ps

module srr_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  srr_pkg::t_cmd                        i_cmd,
    output srr_pkg::t_status                     o_sts,
    input  logic [srr_pkg::SEQ_IN_W-1:0]         i_seq_num,
    input  logic                                 i_checksum_good,
    input  logic [srr_pkg::PAY_W-1:0]            i_payload_word,
    input  logic                                 i_win_we,
    input  logic [srr_pkg::WIN_W-1:0]            i_win_data,
    output logic [srr_pkg::WIN_W-1:0]            o_window_size,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic                                 o_deliver_valid,
    output logic [srr_pkg::PAY_W-1:0]            o_delivered_payload,
    output logic signed [srr_pkg::ACK_W-1:0]     o_ack_number,
    output logic                                 o_last_of_run
);

    localparam int CW = srr_pkg::ACK_W;  // width for mixed-range compares

    logic [srr_pkg::SEQ_IN_W-1:0] r_seq;
    logic                         r_good;
    logic [srr_pkg::PAY_W-1:0]    r_pay;
    logic [srr_pkg::SEQ_W-1:0]    r_exp;
    logic [srr_pkg::ACK_W-1:0]    r_last_ack;
    logic [srr_pkg::SEQ_MOD-1:0]  r_slot_valid;
    logic [srr_pkg::PAY_W-1:0]    r_slot_pay [srr_pkg::SEQ_MOD];
    logic [srr_pkg::WIN_W-1:0]    r_window;
    logic [srr_pkg::CNT_W-1:0]    r_cnt;

    logic                         r_out_valid;
    logic                         r_dv;
    logic [srr_pkg::PAY_W-1:0]    r_dpay;
    logic [srr_pkg::ACK_W-1:0]    r_ack;
    logic                         r_last;

    logic [srr_pkg::SEQ_W-1:0]    seq_idx;
    logic                         in_range;
    logic                         in_order;
    logic [CW-1:0]                ahead;
    logic [CW-1:0]                win_eff;
    logic                         store;
    logic [srr_pkg::SEQ_W-1:0]    exp_next;
    logic                         run_last;
    logic                         out_free;

    assign seq_idx  = r_seq[srr_pkg::SEQ_W-1:0];
    assign in_range = CW'(r_seq) < CW'(srr_pkg::SEQ_MOD);
    assign in_order = r_good && in_range && (seq_idx == r_exp);

    // Distance ahead of the expected number, wrapping modulo SEQ_MOD
    always_comb begin
        if (seq_idx >= r_exp) begin
            ahead = CW'(seq_idx) - CW'(r_exp);
        end else begin
            ahead = CW'(seq_idx) + CW'(srr_pkg::SEQ_MOD) - CW'(r_exp);
        end
        if (CW'(r_window) > CW'(srr_pkg::SEQ_MOD - 1)) begin
            win_eff = CW'(srr_pkg::SEQ_MOD - 1);
        end else begin
            win_eff = CW'(r_window);
        end
    end

    assign store = r_good && in_range && (in_order || (ahead < win_eff))
                   && !r_slot_valid[seq_idx];

    assign exp_next = (r_exp == srr_pkg::SEQ_W'(srr_pkg::SEQ_MOD - 1))
                      ? '0 : r_exp + 1'b1;
    assign run_last = (r_cnt == srr_pkg::CNT_W'(srr_pkg::MAX_RESULTS - 1))
                      || !r_slot_valid[exp_next];
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_sts.in_order = in_order;
        o_sts.out_free = out_free;
        o_sts.run_last = run_last;
    end

    // Captured packet
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_seq  <= i_seq_num;
            r_good <= i_checksum_good;
            r_pay  <= i_payload_word;
        end
    end

    // Slot payload store; occupied slots are never overwritten
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && store) begin
            r_slot_pay[seq_idx] <= r_pay;
        end
        if (i_cmd.load_ack) begin
            r_dpay <= '0;
        end else if (i_cmd.load_dlv) begin
            r_dpay <= r_slot_pay[r_exp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp        <= '0;
            r_last_ack   <= srr_pkg::ACK_NONE;
            r_slot_valid <= '0;
            r_window     <= srr_pkg::WINDOW_RESET;
            r_cnt        <= '0;
        end else begin
            if (i_win_we) begin
                r_window <= i_win_data;
            end
            if (i_cmd.eval) begin
                r_cnt <= '0;
                if (store) begin
                    r_slot_valid[seq_idx] <= 1'b1;
                end
            end else if (i_cmd.load_dlv) begin
                // Deliver the head slot and advance
                r_slot_valid[r_exp] <= 1'b0;
                r_exp               <= exp_next;
                r_last_ack          <= srr_pkg::ACK_W'(r_exp);
                r_cnt               <= r_cnt + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_ack || i_cmd.load_dlv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ack) begin
            r_dv   <= 1'b0;
            r_ack  <= r_last_ack;
            r_last <= 1'b1;
        end else if (i_cmd.load_dlv) begin
            r_dv   <= 1'b1;
            r_ack  <= srr_pkg::ACK_W'(r_exp);
            r_last <= run_last;
        end
    end

    assign o_window_size       = r_window;
    assign o_valid             = r_out_valid;
    assign o_deliver_valid     = r_dv;
    assign o_delivered_payload = r_dpay;
    assign o_ack_number        = r_ack;
    assign o_last_of_run       = r_last;

endmodule

// ----- hdl/selective_repeat_receiver_top.sv -----
// Top level of the selective-repeat receiver: APB register port and block wiring.
`timescale 1ns / 1ps

// One packet beat is taken in the idle state, evaluated in the next cycle
// (slot write, window check), then its results leave through a single output
// register. A corrupted, out-of-order or out-of-range packet gives one result
// that repeats the last ack, so such a packet passes through the evaluate and
// ack states before the block is idle again. An in-order packet drains its run
// of consecutive buffered slots, one delivery per cycle from the slot buffer
// while the output is free, at most eight per packet. Back-pressure on the
// output holds the block in its ack or drain state. The next packet is
// accepted once the last result of a run is in the output register, even if
// it has not yet been taken. The window_size register (byte address 0) may be
// written only while the block is idle; slot valid bits clear at reset.
module selective_repeat_receiver_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // packet input
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [srr_pkg::SEQ_IN_W-1:0]         i_seq_num,
    input  logic                                 i_checksum_good,
    input  logic [srr_pkg::PAY_W-1:0]            i_payload_word,
    // result output
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_deliver_valid,
    output logic [srr_pkg::PAY_W-1:0]            o_delivered_payload,
    output logic signed [srr_pkg::ACK_W-1:0]     o_ack_number,
    output logic                                 o_last_of_run,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [srr_pkg::ADDR_W-1:0]           paddr,
    input  logic [srr_pkg::DATA_W-1:0]           pwdata,
    output logic [srr_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    srr_pkg::t_cmd              cmd;
    srr_pkg::t_status           sts;
    logic                       win_we;
    logic [srr_pkg::WIN_W-1:0]  window_size;
    logic                       sel_window;

    assign pready     = 1'b1;
    assign sel_window = (paddr[srr_pkg::ADDR_W-1] == srr_pkg::REG_WINDOW_SIZE);
    assign win_we     = psel && penable && pwrite && pready && sel_window;
    assign prdata     = sel_window ? srr_pkg::DATA_W'(window_size) : '0;
    assign o_ready    = cmd.in_ready;

    srr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    srr_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_seq_num           (i_seq_num),
        .i_checksum_good     (i_checksum_good),
        .i_payload_word      (i_payload_word),
        .i_win_we            (win_we),
        .i_win_data          (pwdata[srr_pkg::WIN_W-1:0]),
        .o_window_size       (window_size),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_deliver_valid     (o_deliver_valid),
        .o_delivered_payload (o_delivered_payload),
        .o_ack_number        (o_ack_number),
        .o_last_of_run       (o_last_of_run)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the selective-repeat receiver top level.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 1500;
    localparam int HOLD_CYCLES    = 120;
    localparam int ITEMS_PER_WIN  = 46;

    typedef struct packed {
        logic                      deliver;
        logic [srr_pkg::PAY_W-1:0] payload;
        logic [srr_pkg::ACK_W-1:0] ack;
        logic                      last;
    } t_rx_result;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic [srr_pkg::SEQ_IN_W-1:0]     i_seq_num;
    logic                             i_checksum_good;
    logic [srr_pkg::PAY_W-1:0]        i_payload_word;
    logic                             o_valid;
    logic                             i_ready;
    logic                             o_deliver_valid;
    logic [srr_pkg::PAY_W-1:0]        o_delivered_payload;
    logic signed [srr_pkg::ACK_W-1:0] o_ack_number;
    logic                             o_last_of_run;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [srr_pkg::ADDR_W-1:0]       paddr;
    logic [srr_pkg::DATA_W-1:0]       pwdata;
    logic [srr_pkg::DATA_W-1:0]       prdata;
    logic                             pready;

    selective_repeat_receiver_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_seq_num           (i_seq_num),
        .i_checksum_good     (i_checksum_good),
        .i_payload_word      (i_payload_word),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_deliver_valid     (o_deliver_valid),
        .o_delivered_payload (o_delivered_payload),
        .o_ack_number        (o_ack_number),
        .o_last_of_run       (o_last_of_run),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // Receiver model state
    logic [srr_pkg::WIN_W-1:0]   window_reg;
    int unsigned                 next_seq;
    logic [srr_pkg::ACK_W-1:0]   last_ack;
    logic [srr_pkg::SEQ_MOD-1:0] slot_full;
    logic [srr_pkg::PAY_W-1:0]   slot_word [srr_pkg::SEQ_MOD];
    t_rx_result                  results_due [$];

    int mismatches  = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int rx_phase    = 0;
    t_rx_mode rx_mode = RX_OPEN;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Work out the result beats one accepted packet causes and update the model.
    function automatic void predict_packet(input logic [srr_pkg::SEQ_IN_W-1:0] seq,
                                           input logic good,
                                           input logic [srr_pkg::PAY_W-1:0] word);
        int          n;
        int unsigned ahead;
        int unsigned win;
        t_rx_result  r;
        n = 0;
        if (good && seq < srr_pkg::SEQ_MOD && seq == next_seq) begin
            if (!slot_full[seq]) begin
                slot_full[seq] = 1'b1;
                slot_word[seq] = word;
            end
            while (n < srr_pkg::MAX_RESULTS && slot_full[next_seq]) begin
                last_ack  = srr_pkg::ACK_W'(next_seq);
                r.deliver = 1'b1;
                r.payload = slot_word[next_seq];
                r.ack     = last_ack;
                slot_full[next_seq] = 1'b0;
                next_seq  = (next_seq + 1) % srr_pkg::SEQ_MOD;
                n++;
                r.last    = (n == srr_pkg::MAX_RESULTS) || !slot_full[next_seq];
                results_due.push_back(r);
            end
        end else begin
            if (good && seq < srr_pkg::SEQ_MOD) begin
                ahead = (seq + srr_pkg::SEQ_MOD - next_seq) % srr_pkg::SEQ_MOD;
                win   = (window_reg > srr_pkg::SEQ_MOD - 1) ? srr_pkg::SEQ_MOD - 1
                                                            : window_reg;
                if (ahead < win && !slot_full[seq]) begin
                    slot_full[seq] = 1'b1;
                    slot_word[seq] = word;
                end
            end
            r.deliver = 1'b0;
            r.payload = '0;
            r.ack     = last_ack;
            r.last    = 1'b1;
            results_due.push_back(r);
        end
    endfunction

    // Offer one packet beat, with random bursts and gaps, and hold it until taken.
    task automatic send_packet(input logic [srr_pkg::SEQ_IN_W-1:0] seq, input logic good,
                               input logic [srr_pkg::PAY_W-1:0] word);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_valid         <= 1'b1;
        i_seq_num       <= seq;
        i_checksum_good <= good;
        i_payload_word  <= word;
        do @(posedge i_clk); while (!o_ready);
        predict_packet(seq, good, word);
    endtask

    // Mostly well-formed traffic around the expected number, plus corrupt and stray beats.
    task automatic send_random_packet();
        int                           pick;
        logic [srr_pkg::SEQ_IN_W-1:0] seq;
        logic                         good;
        pick = $urandom_range(0, 99);
        good = 1'b1;
        if (pick < 45) begin
            seq = srr_pkg::SEQ_IN_W'(next_seq);
        end else if (pick < 80) begin
            seq = srr_pkg::SEQ_IN_W'((next_seq + $urandom_range(1, srr_pkg::SEQ_MOD - 1))
                                     % srr_pkg::SEQ_MOD);
        end else if (pick < 90) begin
            seq  = srr_pkg::SEQ_IN_W'($urandom_range(0, srr_pkg::SEQ_MOD - 1));
            good = 1'b0;
        end else begin
            seq  = srr_pkg::SEQ_IN_W'($urandom_range(0, 255));
            good = 1'(($urandom_range(0, 1)));
        end
        send_packet(seq, good, {$urandom, $urandom});
    endtask

    // Drain, let the block settle, then write and read back the window register.
    task automatic write_window(input logic [srr_pkg::WIN_W-1:0] w);
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= srr_pkg::ADDR_W'({srr_pkg::REG_WINDOW_SIZE, 2'b00});
        pwdata  <= srr_pkg::DATA_W'(w);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        window_reg = w;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[srr_pkg::WIN_W-1:0] !== w) begin
            $error("window_size: expected %0d, got %0d", w, prdata[srr_pkg::WIN_W-1:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        burst_left = 0;
    endtask

    task automatic test_reset_defaults();
        send_packet(srr_pkg::SEQ_IN_W'(0), 1'b0, {srr_pkg::PAY_W{1'b1}});
        send_packet(srr_pkg::SEQ_IN_W'(255), 1'b1, 64'h0123_4567_89ab_cdef);
        send_packet(srr_pkg::SEQ_IN_W'(srr_pkg::SEQ_MOD), 1'b1, '0);
        send_packet(srr_pkg::SEQ_IN_W'(0), 1'b1, {srr_pkg::PAY_W{1'b1}});
    endtask

    task automatic test_reorder_default_window();
        send_packet(srr_pkg::SEQ_IN_W'(2), 1'b1, 64'haaaa_aaaa_aaaa_aaaa);
        send_packet(srr_pkg::SEQ_IN_W'(3), 1'b1, 64'h5555_5555_5555_5555);
        // occupied slot: this word must be dropped
        send_packet(srr_pkg::SEQ_IN_W'(3), 1'b1, 64'hdead_beef_dead_beef);
        send_packet(srr_pkg::SEQ_IN_W'(5), 1'b1, 64'h0000_0000_ffff_ffff);
        send_packet(srr_pkg::SEQ_IN_W'(4), 1'b0, 64'hffff_ffff_0000_0000);
        send_packet(srr_pkg::SEQ_IN_W'(1), 1'b1, 64'h8000_0000_0000_0001);
        send_packet(srr_pkg::SEQ_IN_W'(4), 1'b1, '0);
    endtask

    task automatic test_window_extremes();
        int unsigned base;
        write_window(srr_pkg::WIN_W'(7));
        base = next_seq;
        for (int k = 1; k < srr_pkg::SEQ_MOD - 1; k++)
            send_packet(srr_pkg::SEQ_IN_W'((base + k) % srr_pkg::SEQ_MOD), 1'b1,
                        {$urandom, $urandom});
        // longest drain: expected packet releases the whole window
        send_packet(srr_pkg::SEQ_IN_W'(base), 1'b1, {$urandom, $urandom});
        write_window(srr_pkg::WIN_W'(0));
        send_packet(srr_pkg::SEQ_IN_W'((next_seq + 1) % srr_pkg::SEQ_MOD), 1'b1,
                    {$urandom, $urandom});
        send_packet(srr_pkg::SEQ_IN_W'(next_seq), 1'b1, {$urandom, $urandom});
        send_packet(srr_pkg::SEQ_IN_W'((next_seq + 1) % srr_pkg::SEQ_MOD), 1'b1,
                    {$urandom, $urandom});
    endtask

    task automatic test_backpressure_fill();
        write_window(srr_pkg::WIN_W'(5));
        gaps_on = 1'b0;
        hold_reqs++;
        repeat (24) send_random_packet();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [srr_pkg::WIN_W-1:0] windows [8];
        windows = '{srr_pkg::WIN_W'(1), srr_pkg::WIN_W'(3), srr_pkg::WIN_W'(6),
                    srr_pkg::WIN_W'(2), srr_pkg::WIN_W'(7), srr_pkg::WIN_W'(4),
                    srr_pkg::WIN_W'(0), srr_pkg::WIN_W'(5)};
        foreach (windows[i]) begin
            write_window(windows[i]);
            repeat (ITEMS_PER_WIN) send_random_packet();
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_rx_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                $error("result beat with nothing expected: ack_number %0d", o_ack_number);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (o_deliver_valid !== want.deliver) begin
                    $error("deliver_valid: expected %0b, got %0b", want.deliver,
                           o_deliver_valid);
                    mismatches++;
                end
                if (o_delivered_payload !== want.payload) begin
                    $error("delivered_payload: expected %h, got %h", want.payload,
                           o_delivered_payload);
                    mismatches++;
                end
                if (o_ack_number !== want.ack) begin
                    $error("ack_number: expected %0d, got %0d", $signed(want.ack),
                           o_ack_number);
                    mismatches++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Output stall pattern; a requested hold-off overrides it
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (rx_phase == 0) begin
            rx_mode  = t_rx_mode'($urandom_range(0, 3));
            rx_phase = $urandom_range(20, 80);
        end
        rx_phase--;
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= 1'(($urandom_range(0, 1)));
                RX_SPARSE: i_ready <= (rx_phase % 4 == 0);
                default:   i_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_seq_num       <= '0;
        i_checksum_good <= 1'b0;
        i_payload_word  <= '0;
        i_ready         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        window_reg = srr_pkg::WINDOW_RESET;
        next_seq   = 0;
        last_ack   = srr_pkg::ACK_NONE;
        slot_full  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_reorder_default_window();
        test_window_extremes();
        test_backpressure_fill();
        test_random_traffic();

        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
